[rtl/tea_block_cipher_assert.svh]
// Assertion macros for the checker file of the cipher block.
`ifndef TEA_BLOCK_CIPHER_ASSERT_SVH
`define TEA_BLOCK_CIPHER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TEA_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("tea_block_cipher assertion failed");

// Checked on every clock edge, reset included.
`define TEA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("tea_block_cipher reset assertion failed");

`endif

[rtl/tea_pkg.sv]
`default_nettype none

package tea_pkg;

    localparam logic [31:0] TeaDelta = 32'h9e37_79b9;
    localparam logic [31:0] TeaKeyHi = 32'h3543_5898;
    localparam logic [31:0] TeaKeyLo = 32'h2384_7238;

    localparam logic [31:0] KeyZeroReset  = (TeaKeyHi & 32'hFFFF_0000) >> 16;
    localparam logic [31:0] KeyOneReset   = TeaKeyHi & 32'h0000_FFFF;
    localparam logic [31:0] KeyTwoReset   = (TeaKeyLo & 32'hFFFF_0000) >> 16;
    localparam logic [31:0] KeyThreeReset = TeaKeyLo & 32'h0000_FFFF;

    typedef enum logic [1:0] {
        CFG_KEY_ZERO  = 2'd0,
        CFG_KEY_ONE   = 2'd1,
        CFG_KEY_TWO   = 2'd2,
        CFG_KEY_THREE = 2'd3
    } tea_cfg_idx_t;

    typedef struct packed {
        logic [31:0] k0;
        logic [31:0] k1;
        logic [31:0] k2;
        logic [31:0] k3;
    } tea_key_t;

    typedef struct packed {
        logic        dec;
        logic [31:0] v0;
        logic [31:0] v1;
    } tea_item_t;

endpackage

`default_nettype wire

[rtl/tea_half_round.sv]
`default_nettype none

module tea_half_round #(
    parameter logic [31:0] SUM_ENC     = 32'h9e37_79b9,
    parameter logic [31:0] SUM_DEC     = 32'hc6ef_3720,
    parameter bit          SECOND_HALF = 1'b0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              ce,
    input  wire logic              in_valid,
    input  wire tea_pkg::tea_item_t in_item,
    input  wire tea_pkg::tea_key_t  key,
    output logic                   out_valid,
    output tea_pkg::tea_item_t     out_item
);
    import tea_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    tea_item_t   item_reg;
    tea_item_t   item_next;
    logic        upd_v0;
    logic [31:0] sum;
    logic [31:0] x;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] target;
    logic [31:0] f;
    logic [31:0] updated;

    // Encryption updates the first word in the first half; decryption swaps the order.
    always_comb begin
        upd_v0  = (SECOND_HALF == 1'b0) != in_item.dec;
        sum     = in_item.dec ? SUM_DEC : SUM_ENC;
        x       = upd_v0 ? in_item.v1 : in_item.v0;
        ka      = upd_v0 ? key.k0 : key.k2;
        kb      = upd_v0 ? key.k1 : key.k3;
        target  = upd_v0 ? in_item.v0 : in_item.v1;
        f       = ((x << 4) + ka) ^ (x + sum) ^ ({{5{x[31]}}, x[31:5]} + kb);
        updated = in_item.dec ? (target - f) : (target + f);

        item_next     = in_item;
        if (upd_v0) begin
            item_next.v0 = updated;
        end else begin
            item_next.v1 = updated;
        end
        valid_next = in_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
        if (ce) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

[rtl/tea_block_cipher.sv]
// TEA block cipher with an arithmetic right shift, one 64-bit block per transaction.
// Each of the 2*ROUNDS pipeline stages computes one half-round, so a block is
// accepted on every cycle while s_tready is high, and its result reaches m_tvalid
// through the half-round stages and then the output register. An output register
// plus one skid register decouple the result side; s_tready falls only when both
// hold results that have not been taken. Keys are to be written through the cfg
// port only while no block is in flight; the block itself does not enforce this.
`default_nettype none

module tea_block_cipher #(
    parameter int unsigned ROUNDS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // first_word [31:0], second_word [63:32]
    input  wire logic        s_tuser,   // func: 0 encrypt, 1 decrypt
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // first_result [31:0], second_result [63:32]
);
    import tea_pkg::*;

    localparam int unsigned NStage = 2 * ROUNDS;

    tea_key_t  key_reg;
    tea_key_t  key_next;
    logic      ce;
    logic      stage_valid [0:NStage];
    tea_item_t stage_item  [0:NStage];
    logic      out_valid_reg;
    logic      out_valid_next;
    tea_item_t out_item_reg;
    tea_item_t out_item_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    tea_item_t skid_item_reg;
    tea_item_t skid_item_next;
    logic      pop;

    always_comb begin
        key_next = key_reg;
        if (cfg_wr_en) begin
            case (tea_cfg_idx_t'(cfg_index))
                CFG_KEY_ZERO:  key_next.k0 = cfg_data;
                CFG_KEY_ONE:   key_next.k1 = cfg_data;
                CFG_KEY_TWO:   key_next.k2 = cfg_data;
                CFG_KEY_THREE: key_next.k3 = cfg_data;
                default:       key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '{k0: KeyZeroReset, k1: KeyOneReset,
                         k2: KeyTwoReset, k3: KeyThreeReset};
        end else begin
            key_reg <= key_next;
        end
    end

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    assign stage_valid[0] = s_tvalid;
    assign stage_item[0]  = '{dec: s_tuser, v0: s_tdata[31:0], v1: s_tdata[63:32]};

    for (genvar g = 0; g < NStage; g++) begin : g_stage
        localparam int unsigned Round = g / 2;
        localparam logic [31:0] SumEnc = TeaDelta * 32'(Round + 1);
        localparam logic [31:0] SumDec = TeaDelta * 32'(ROUNDS - Round);

        tea_half_round #(
            .SUM_ENC     (SumEnc),
            .SUM_DEC     (SumDec),
            .SECOND_HALF ((g % 2) == 1)
        ) u_half (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (stage_valid[g]),
            .in_item   (stage_item[g]),
            .key       (key_reg),
            .out_valid (stage_valid[g+1]),
            .out_item  (stage_item[g+1])
        );
    end

    assign pop = out_valid_reg && m_tready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end else if (stage_valid[NStage]) begin
            if (!out_valid_reg || pop) begin
                out_item_next  = stage_item[NStage];
                out_valid_next = 1'b1;
            end else begin
                skid_item_next  = stage_item[NStage];
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_item_reg.v1, out_item_reg.v0};

endmodule

`default_nettype wire

[rtl/tea_checker.sv]
`default_nettype none

`include "tea_block_cipher_assert.svh"

module tea_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);

    `TEA_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (!m_tvalid && s_tready))

    `TEA_ASSERT(a_stall_only_when_full, !s_tready |-> m_tvalid)

    `TEA_ASSERT(a_full_holds, (!s_tready && !m_tready) |=> !s_tready)

    `TEA_ASSERT(a_result_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind tea_block_cipher tea_checker u_tea_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/tea_block_cipher_tb.sv]
`timescale 1ns / 1ps

module tea_block_cipher_tb;
    import tea_pkg::*;

    localparam int unsigned NUM_ROUNDS = 32;
    localparam int unsigned LATENCY = 2 * NUM_ROUNDS + 1;
    localparam int unsigned RANDOM_PER_PHASE = 180;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned MAX_REPORTS = 200;

    // Corner blocks as {second_word, first_word}.
    localparam logic [63:0] CORNER_BLOCKS [8] = '{
        64'h0000_0000_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_8000_0000,
        64'h8000_0000_0000_0000,
        64'hFFFF_FFFF_7FFF_FFFF,
        64'h8000_0000_8000_0000,
        64'h5555_5555_AAAA_AAAA,
        64'h89AB_CDEF_0123_4567
    };

    class tea_scoreboard;
        tea_key_t key;
        logic [63:0] expected_blocks[$];
        int unsigned errors;

        function new();
            key.k0 = KeyZeroReset;
            key.k1 = KeyOneReset;
            key.k2 = KeyTwoReset;
            key.k3 = KeyThreeReset;
            errors = 0;
        endfunction

        function void set_key(tea_cfg_idx_t idx, logic [31:0] value);
            case (idx)
                CFG_KEY_ZERO: begin
                    key.k0 = value;
                end
                CFG_KEY_ONE: begin
                    key.k1 = value;
                end
                CFG_KEY_TWO: begin
                    key.k2 = value;
                end
                CFG_KEY_THREE: begin
                    key.k3 = value;
                end
                default: begin
                end
            endcase
        endfunction

        // The right shift by five keeps the sign bit.
        function logic [31:0] half_round(logic [31:0] x, logic [31:0] ka, logic [31:0] kb,
                                         logic [31:0] delta_sum);
            logic [31:0] shifted;
            shifted = $signed(x) >>> 5;
            return ((x << 4) + ka) ^ (x + delta_sum) ^ (shifted + kb);
        endfunction

        function logic [63:0] tea_transform(logic dec, logic [31:0] w0, logic [31:0] w1);
            logic [31:0] v0;
            logic [31:0] v1;
            logic [31:0] delta_sum;
            v0 = w0;
            v1 = w1;
            if (!dec) begin
                delta_sum = '0;
                for (int i = 0; i < NUM_ROUNDS; i++) begin
                    delta_sum += TeaDelta;
                    v0 += half_round(v1, key.k0, key.k1, delta_sum);
                    v1 += half_round(v0, key.k2, key.k3, delta_sum);
                end
            end else begin
                delta_sum = TeaDelta * NUM_ROUNDS;
                for (int i = 0; i < NUM_ROUNDS; i++) begin
                    v1 -= half_round(v0, key.k2, key.k3, delta_sum);
                    v0 -= half_round(v1, key.k0, key.k1, delta_sum);
                    delta_sum -= TeaDelta;
                end
            end
            return {v1, v0};
        endfunction

        function void note_block(logic dec, logic [63:0] data);
            expected_blocks.push_back(tea_transform(dec, data[31:0], data[63:32]));
        endfunction

        function void check_result(logic [63:0] data);
            logic [63:0] want;
            if (expected_blocks.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h", $time, data);
                return;
            end
            want = expected_blocks.pop_front();
            if (data[31:0] !== want[31:0]) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: first_result expected %h actual %h",
                             $time, want[31:0], data[31:0]);
            end
            if (data[63:32] !== want[63:32]) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: second_result expected %h actual %h",
                             $time, want[63:32], data[63:32]);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_KEY_ZERO;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    tea_scoreboard sb;
    int unsigned burst_left = 0;
    int unsigned ready_hold = 0;
    int unsigned idle_cycles = 0;

    tea_block_cipher #(
        .ROUNDS(NUM_ROUNDS)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 5) begin
            burst_left = $urandom_range(80, 20);
            return 0;
        end
        if (roll < 50)
            return 0;
        if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(15))
            0: begin
                return 32'h0000_0000;
            end
            1: begin
                return 32'hFFFF_FFFF;
            end
            2: begin
                return 32'h8000_0000 | $urandom_range(255);
            end
            3: begin
                return 32'h7FFF_FFFF;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic send_block(input logic dec, input logic [31:0] w0, input logic [31:0] w1);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= dec;
        s_tdata <= {w1, w0};
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_blocks.size() != 0) @(posedge aclk);
    endtask

    task automatic write_key(input tea_cfg_idx_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        sb.set_key(idx, value);
    endtask

    task automatic load_keys(input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3);
        write_key(CFG_KEY_ZERO, k0);
        write_key(CFG_KEY_ONE, k1);
        write_key(CFG_KEY_TWO, k2);
        write_key(CFG_KEY_THREE, k3);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random(input int unsigned count);
        logic [63:0] blk;
        logic [63:0] cipher_blk;
        int unsigned sent;
        sent = 0;
        while (sent < count) begin
            blk = {rand_word(), rand_word()};
            if ($urandom_range(4) == 0) begin
                // Encrypt a block, then decrypt its ciphertext.
                send_block(1'b0, blk[31:0], blk[63:32]);
                cipher_blk = sb.tea_transform(1'b0, blk[31:0], blk[63:32]);
                send_block(1'b1, cipher_blk[31:0], cipher_blk[63:32]);
                sent += 2;
            end else begin
                send_block(1'($urandom_range(1)), blk[31:0], blk[63:32]);
                sent++;
            end
        end
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready === 1'b1)
                sb.note_block(s_tuser, s_tdata);
            if (m_tvalid === 1'b1 && m_tready)
                sb.check_result(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_tready) begin
            m_tready <= 1'b0;
            ready_hold <= ($urandom_range(9) == 0) ? $urandom_range(60, 15)
                                                   : $urandom_range(2, 0);
        end else begin
            m_tready <= 1'b1;
            ready_hold <= ($urandom_range(7) == 0) ? $urandom_range(300, 60)
                                                   : $urandom_range(6, 0);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [63:0] cipher_blk;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (CORNER_BLOCKS[i]) begin
            send_block(1'b0, CORNER_BLOCKS[i][31:0], CORNER_BLOCKS[i][63:32]);
            send_block(1'b1, CORNER_BLOCKS[i][31:0], CORNER_BLOCKS[i][63:32]);
        end
        cipher_blk = sb.tea_transform(1'b0, CORNER_BLOCKS[7][31:0], CORNER_BLOCKS[7][63:32]);
        send_block(1'b1, cipher_blk[31:0], cipher_blk[63:32]);
        run_random(RANDOM_PER_PHASE + 20);

        load_keys(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        run_random(RANDOM_PER_PHASE);
        load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(RANDOM_PER_PHASE);
        load_keys(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        run_random(RANDOM_PER_PHASE);
        repeat (3) begin
            load_keys($urandom, $urandom, $urandom, $urandom);
            run_random(RANDOM_PER_PHASE);
        end

        repeat (LATENCY + 10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_blocks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
